// File: rtl/iep_pkg.sv
// Shared constants, command codes and the cell control bundle for the
// interval emptiness point store. No dependencies.
`default_nettype none

package iep_pkg;

	localparam int STORE_DEPTH = 512;
	localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int POINT_W     = 64;
	localparam int CMD_W       = 2;
	localparam int ENTRY_W     = 10;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic wr;    // insert at the cell whose index equals the count
		logic clr;   // clear the running hit flag
		logic scan;  // advance the hit flag one cell
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/interval_emptiness_point_store.sv
// Interval emptiness point store: a chain of STORE_DEPTH point cells and
// the sequencer that feeds it. Insert, clear and the unused command give their
// result in the output register in the cycle after the transfer, one item per cycle
// while the output is not stalled. A query moves the hit flag one cell per cycle
// through the chain and gives its result from ST_DONE once the output is free; no
// transfer is taken until then. Reset zeroes count and control; points stay undefined.
`default_nettype none

module interval_emptiness_point_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [iep_pkg::CMD_W-1:0]     command,
	input  logic [iep_pkg::POINT_W-1:0]   point_value,
	input  logic [iep_pkg::POINT_W-1:0]   range_low,
	input  logic [iep_pkg::POINT_W-1:0]   range_high,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          range_empty,
	output logic                          store_full,
	output logic [iep_pkg::ENTRY_W-1:0]   entry_count
);
	import iep_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t               state_q;
	state_t               state_d;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_d;
	logic [IDX_W-1:0]     scan_cnt_q;
	logic [POINT_W-1:0]   rlo_q;
	logic [POINT_W-1:0]   rhi_q;
	logic                 out_valid_q;
	logic                 range_empty_q;
	logic                 store_full_q;
	logic [ENTRY_W-1:0]   entry_count_q;

	logic                 out_free;
	logic                 accept;
	logic                 is_full;
	logic                 scan_last;
	cell_ctl_t            ctl;
	logic [STORE_DEPTH:0] acc_chain;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == ST_IDLE) && out_free);
	assign accept    = in_valid && !in_stall;
	assign is_full   = (count_q == CNT_W'(STORE_DEPTH));
	assign scan_last = (scan_cnt_q == IDX_W'(STORE_DEPTH - 1));

	always_comb begin
		ctl.wr   = accept && (command == CMD_INSERT) && !is_full;
		ctl.clr  = accept && (command == CMD_QUERY);
		ctl.scan = (state_q == ST_SCAN);
	end

	always_comb begin
		count_d = count_q;
		if (accept) begin
			unique case (command)
				CMD_INSERT: if (!is_full) count_d = count_q + CNT_W'(1);
				CMD_CLEAR:  count_d = '0;
				default:    count_d = count_q;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && (command == CMD_QUERY)) state_d = ST_SCAN;
			ST_SCAN: if (scan_last) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign acc_chain[0] = 1'b0;

	for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
		iep_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.idx        (IDX_W'(i)),
			.count      (count_q),
			.wr_point   (point_value),
			.range_low  (rlo_q),
			.range_high (rhi_q),
			.acc_in     (acc_chain[i]),
			.acc_out    (acc_chain[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			rlo_q <= range_low;
			rhi_q <= range_high;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			scan_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (ctl.clr) begin
				scan_cnt_q <= '0;
			end else if (ctl.scan && !scan_last) begin
				scan_cnt_q <= scan_cnt_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && (command != CMD_QUERY)) ||
		             ((state_q == ST_DONE) && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (command != CMD_QUERY)) begin
			range_empty_q <= 1'b0;
			store_full_q  <= (command == CMD_INSERT) && is_full;
			entry_count_q <= ENTRY_W'(count_d);
		end else if ((state_q == ST_DONE) && out_free) begin
			range_empty_q <= !acc_chain[STORE_DEPTH];
			store_full_q  <= 1'b0;
			entry_count_q <= ENTRY_W'(count_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign range_empty = range_empty_q;
	assign store_full  = store_full_q;
	assign entry_count = entry_count_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STORE_DEPTH))
		else $error("entry count above store depth");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (command == CMD_INSERT) && is_full) |=> (count_q == CNT_W'(STORE_DEPTH)))
		else $error("dropped insert changed the count");

	a_query_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (command == CMD_QUERY)) |=> ((state_q == ST_SCAN) && !out_valid_q))
		else $error("query transfer did not start a scan");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && store_full_q) |-> (entry_count_q == ENTRY_W'(STORE_DEPTH)))
		else $error("full flag without a full store");

endmodule

`default_nettype wire

// File: rtl/iep_cell.sv
// One storage cell of the point chain: holds a point, compares it against
// the held range and forwards the running hit flag. Depends on iep_pkg.
`default_nettype none

module iep_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  iep_pkg::cell_ctl_t           ctl,
	input  logic [iep_pkg::IDX_W-1:0]    idx,
	input  logic [iep_pkg::CNT_W-1:0]    count,
	input  logic [iep_pkg::POINT_W-1:0]  wr_point,
	input  logic [iep_pkg::POINT_W-1:0]  range_low,
	input  logic [iep_pkg::POINT_W-1:0]  range_high,
	input  logic                         acc_in,
	output logic                         acc_out
);
	import iep_pkg::*;

	logic [POINT_W-1:0] point_q;
	logic               acc_q;
	logic               valid;
	logic               sel;
	logic               hit;

	assign sel   = (CNT_W'(idx) == count);
	assign valid = (CNT_W'(idx) < count);
	// A reversed range fails one of the two bounds, so it never hits.
	assign hit   = valid && (point_q >= range_low) && (point_q <= range_high);

	always_ff @(posedge clk) begin
		if (ctl.wr && sel) begin
			point_q <= wr_point;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 1'b0;
		end else if (ctl.clr) begin
			acc_q <= 1'b0;
		end else if (ctl.scan) begin
			acc_q <= acc_in | hit;
		end
	end

	assign acc_out = acc_q;

endmodule

`default_nettype wire

// File: tb/interval_emptiness_point_store_test.sv
// Self-checking testbench for interval_emptiness_point_store: insert, clear and
// range queries with random idling on both channels, checked by a scoreboard.
// Depends on iep_pkg and the interval_emptiness_point_store RTL.
`timescale 1ns / 100ps

module interval_emptiness_point_store_test;
	import iep_pkg::*;

	localparam logic [CMD_W-1:0]   CMD_UNUSED  = 2'd3;
	localparam logic [POINT_W-1:0] POINT_MAX   = '1;
	localparam logic [POINT_W-1:0] HALF_BIT    = 64'h8000_0000_0000_0000;
	localparam logic [POINT_W-1:0] ALT_01      = 64'h5555_5555_5555_5555;
	localparam logic [POINT_W-1:0] ALT_10      = 64'hAAAA_AAAA_AAAA_AAAA;
	localparam int                 IDLE_LIMIT  = 4000;
	localparam int                 HOLD_CYCLES = 400;

	typedef struct {
		logic [CMD_W-1:0]   cmd;
		logic [POINT_W-1:0] pt;
		logic [POINT_W-1:0] lo;
		logic [POINT_W-1:0] hi;
	} stim_t;

	class point_store_scoreboard;
		typedef struct {
			logic               empty;
			logic               full;
			logic [ENTRY_W-1:0] count;
		} result_t;

		logic [POINT_W-1:0] points [STORE_DEPTH];
		int unsigned        held;
		result_t            expected_results [$];
		int                 errors;

		function bit holds_point_in(logic [POINT_W-1:0] lo, logic [POINT_W-1:0] hi);
			for (int unsigned i = 0; i < held; i++) begin
				if (points[i] >= lo && points[i] <= hi)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_transfer(logic [CMD_W-1:0] cmd, logic [POINT_W-1:0] pt,
				logic [POINT_W-1:0] lo, logic [POINT_W-1:0] hi);
			result_t r;
			r.empty = 1'b0;
			r.full  = 1'b0;
			case (cmd)
				CMD_INSERT: begin
					if (held < STORE_DEPTH) begin
						points[held] = pt;
						held++;
					end else begin
						r.full = 1'b1;
					end
				end
				CMD_CLEAR: held = 0;
				CMD_QUERY: r.empty = !holds_point_in(lo, hi);
				default: ;
			endcase
			r.count = ENTRY_W'(held);
			expected_results = {expected_results, r};
		endfunction

		task report_mismatch(string msg);
			$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic got_empty, logic got_full, logic [ENTRY_W-1:0] got_count);
			result_t r;
			if (expected_results.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
				return;
			end
			r = expected_results.pop_front();
			if (got_empty !== r.empty)
				report_mismatch($sformatf("range_empty %0b, expected %0b", got_empty, r.empty));
			if (got_full !== r.full)
				report_mismatch($sformatf("store_full %0b, expected %0b", got_full, r.full));
			if (got_count !== r.count)
				report_mismatch($sformatf("entry_count %0d, expected %0d", got_count, r.count));
		endtask
	endclass

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_stall;
	logic [CMD_W-1:0]   command     = CMD_INSERT;
	logic [POINT_W-1:0] point_value = '0;
	logic [POINT_W-1:0] range_low   = '0;
	logic [POINT_W-1:0] range_high  = '0;
	logic               out_valid;
	logic               out_stall   = 1'b0;
	logic               range_empty;
	logic               store_full;
	logic [ENTRY_W-1:0] entry_count;

	point_store_scoreboard sb;
	int  idle_pct      = 0;
	int  stall_pct     = 0;
	int  hold_left     = 0;
	bit  hold_request  = 1'b0;
	bit  filling       = 1'b0;
	int  dropped_count = 0;
	int  quiet         = 0;

	interval_emptiness_point_store i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.point_value (point_value),
		.range_low   (range_low),
		.range_high  (range_high),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.range_empty (range_empty),
		.store_full  (store_full),
		.entry_count (entry_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: random stall, or a long hold-off when requested.
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_transfer(command, point_value, range_low, range_high);
			if (out_valid && !out_stall)
				sb.check_result(range_empty, store_full, entry_count);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= IDLE_LIMIT) begin
					$display("watchdog: no transfer for %0d cycles", quiet);
					$display("Mismatches found");
					$finish;
				end
			end
		end
	end

	function automatic logic [POINT_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Mix wide random values with small, near-max and just-above-half-bit ones so duplicates occur.
	function automatic logic [POINT_W-1:0] random_point();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			return rand_word();
		else if (pick < 70)
			return POINT_W'($urandom_range(0, 255));
		else if (pick < 85)
			return POINT_MAX - POINT_W'($urandom_range(0, 255));
		else
			return {32'h8000_0000, $urandom_range(0, 15)};
	endfunction

	function automatic void pick_range(output logic [POINT_W-1:0] lo,
			output logic [POINT_W-1:0] hi);
		logic [POINT_W-1:0] p;
		logic [POINT_W-1:0] a;
		logic [POINT_W-1:0] b;
		int pick;
		pick = $urandom_range(0, 99);
		a = POINT_W'($urandom_range(0, 3));
		b = POINT_W'($urandom_range(0, 3));
		p = (sb.held > 0) ? sb.points[$urandom_range(0, sb.held - 1)] : random_point();
		if (pick < 35) begin
			// window around a stored point (a random one if the store is empty), saturated at both ends
			lo = (p >= a) ? p - a : '0;
			hi = (p <= POINT_MAX - b) ? p + b : POINT_MAX;
		end else if (pick < 50) begin
			lo = p + 1;
			hi = lo + b;
		end else if (pick < 60) begin
			lo = p - a;
			hi = p;
		end else if (pick < 70) begin
			// reversed range
			hi = random_point() >> 1;
			lo = hi + 1 + a;
		end else if (pick < 85) begin
			lo = rand_word();
			hi = rand_word();
		end else if (pick < 92) begin
			lo = '0;
			hi = p;
		end else begin
			lo = p;
			hi = POINT_MAX;
		end
	endfunction

	function automatic stim_t random_item();
		stim_t s;
		int pick;
		pick = $urandom_range(0, 99);
		s.pt = random_point();
		s.lo = rand_word();
		s.hi = rand_word();
		if (filling) begin
			if (pick < 92)
				s.cmd = CMD_INSERT;
			else if (pick < 97)
				s.cmd = CMD_QUERY;
			else
				s.cmd = CMD_UNUSED;
		end else begin
			if (pick < 55)
				s.cmd = CMD_INSERT;
			else if (pick < 88)
				s.cmd = CMD_QUERY;
			else if (pick < 93)
				s.cmd = CMD_CLEAR;
			else
				s.cmd = CMD_UNUSED;
		end
		// leave fill mode once a dozen inserts have hit a full store
		if (s.cmd == CMD_INSERT && sb.held == STORE_DEPTH) begin
			dropped_count++;
			if (dropped_count >= 12)
				filling = 1'b0;
		end
		if (s.cmd == CMD_QUERY)
			pick_range(s.lo, s.hi);
		return s;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_item(logic [CMD_W-1:0] cmd, logic [POINT_W-1:0] pt,
			logic [POINT_W-1:0] lo, logic [POINT_W-1:0] hi);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(0, 99) < idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		command     <= cmd;
		point_value <= pt;
		range_low   <= lo;
		range_high  <= hi;
		in_valid    <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic run_phase(int items, int send_idle, int recv_stall, bit fill_first,
			int hold_at);
		stim_t s;
		idle_pct      = send_idle;
		stall_pct     = recv_stall;
		filling       = fill_first;
		dropped_count = 0;
		for (int n = 0; n < items; n++) begin
			if (n == hold_at)
				hold_request = 1'b1;
			s = random_item();
			send_item(s.cmd, s.pt, s.lo, s.hi);
		end
	endtask

	initial begin
		sb = new();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(CMD_QUERY, rand_word(), '0, POINT_MAX);
		send_item(CMD_INSERT, '0, rand_word(), rand_word());
		send_item(CMD_INSERT, POINT_MAX, rand_word(), rand_word());
		send_item(CMD_INSERT, HALF_BIT, rand_word(), rand_word());
		send_item(CMD_INSERT, ALT_01, rand_word(), rand_word());
		send_item(CMD_INSERT, ALT_10, rand_word(), rand_word());
		send_item(CMD_QUERY, rand_word(), '0, '0);
		send_item(CMD_QUERY, rand_word(), POINT_MAX, POINT_MAX);
		send_item(CMD_QUERY, rand_word(), 64'd1, POINT_MAX - 1);
		send_item(CMD_QUERY, rand_word(), POINT_MAX, '0);
		send_item(CMD_QUERY, rand_word(), 64'd1, ALT_01 - 1);
		send_item(CMD_QUERY, rand_word(), ALT_01 + 1, HALF_BIT - 1);
		send_item(CMD_INSERT, ALT_01, rand_word(), rand_word());
		send_item(CMD_UNUSED, POINT_MAX, POINT_MAX, POINT_MAX);
		send_item(CMD_QUERY, rand_word(), HALF_BIT, HALF_BIT);
		send_item(CMD_CLEAR, POINT_MAX, '0, POINT_MAX);
		send_item(CMD_QUERY, rand_word(), '0, POINT_MAX);
		send_item(CMD_INSERT, 64'd42, rand_word(), rand_word());
		send_item(CMD_QUERY, rand_word(), 64'd42, 64'd42);
		send_item(CMD_QUERY, rand_word(), 64'd43, POINT_MAX);

		run_phase(300, 0, 0, 1'b0, 100);
		run_phase(650, 57, 0, 1'b1, -1);
		run_phase(275, 0, 57, 1'b0, -1);
		run_phase(275, 17, 17, 1'b0, -1);
		in_valid <= 1'b0;

		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (STORE_DEPTH + 8) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
